/* rtl/dese_pkg.sv */
package dese_pkg;

  localparam int FracBits  = 8;
  localparam int TsW       = 32;
  localparam int RateW     = 27;
  localparam int LimitW    = 8;
  localparam int IdleW     = 9;
  localparam int FreqW     = 28;
  localparam int NumW      = RateW + FracBits;
  localparam int DivSteps  = NumW;
  localparam int CntW      = $clog2(DivSteps);
  localparam int NumChan   = 2;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(20);
  localparam logic [RateW-1:0]  RateReset  = RateW'(1000000);
  localparam logic [IdleW-1:0]  IdleMax    = {IdleW{1'b1}};
  localparam logic [FreqW-1:0]  FreqMax    = {FreqW{1'b1}};

  // input item codes
  localparam logic       ModeEdge   = 1'b0;
  localparam logic       ModeUpdate = 1'b1;
  localparam logic [1:0] LvlFall    = 2'd0;
  localparam logic [1:0] LvlRise    = 2'd1;

  // register map, word index taken from paddr[2]
  localparam logic RegIdleLimit = 1'b0;
  localparam logic RegTickRate  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_COMMIT,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic edge_we;
    logic upd_start;
    logic div_step;
    logic commit;
    logic out_load;
  } dp_cmd_t;

endpackage

/* rtl/dese_div.sv */
// restoring divider, one quotient bit per step
module dese_div import dese_pkg::*; (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            step_i,
  input  logic [NumW-1:0] num_i,
  input  logic [TsW-1:0]  den_i,
  output logic [NumW-1:0] quo_o
);

  logic [NumW-1:0] quo_q, quo_d;
  logic [TsW-1:0]  rem_q, rem_d;
  logic [TsW-1:0]  den_q, den_d;
  logic [TsW:0]    rem_sh;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[NumW-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (load_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (step_i) begin
      quo_d = {quo_q[NumW-2:0], fits};
      rem_d = fits ? TsW'(rem_sh - {1'b0, den_q}) : rem_sh[TsW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;

endmodule

/* rtl/dese_ctrl.sv */
// sequencer: item intake, divide count, commit, result handoff
module dese_ctrl import dese_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    mode_i,
  input  logic    out_ready_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (mode_i == ModeUpdate)) state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_COMMIT;
      end
      S_COMMIT: state_d = S_PUSH;
      S_PUSH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.edge_we   = accept && (mode_i == ModeEdge);
        cmd_o.upd_start = accept && (mode_i == ModeUpdate);
      end
      S_DIV:    cmd_o.div_step = 1'b1;
      S_COMMIT: cmd_o.commit   = 1'b1;
      S_PUSH:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = (state_q == S_DIV) ? cnt_q + CntW'(1) : '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/dese_dp.sv */
// per-channel edge timing, idle counting, frequency averaging
module dese_dp import dese_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic              channel_i,
  input  logic [1:0]        level_i,
  input  logic [TsW-1:0]    timestamp_i,
  input  logic [LimitW-1:0] idle_limit_i,
  input  logic [RateW-1:0]  tick_rate_i,
  output logic [FreqW-1:0]  freq_left_o,
  output logic [FreqW-1:0]  freq_right_o
);

  logic [TsW-1:0]   last_q   [NumChan];
  logic [TsW-1:0]   period_q [NumChan];
  logic [NumChan-1:0] seen_q;
  logic [NumChan-1:0] zero_q;
  logic [IdleW-1:0] idle_q   [NumChan];
  logic [IdleW-1:0] idle_d   [NumChan];
  logic [FreqW-1:0] freq_q   [NumChan];
  logic [FreqW-1:0] freq_d   [NumChan];
  logic [NumW-1:0]  quo      [NumChan];
  logic [FreqW-1:0] out_left_q, out_right_q;
  logic [NumW-1:0]  num;
  logic             edge_ok;

  assign num     = {tick_rate_i, FracBits'(0)};
  assign edge_ok = cmd_i.edge_we && (level_i inside {LvlFall, LvlRise});

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    logic [FreqW-1:0] q_sat;
    logic [FreqW:0]   sum;

    dese_div u_div (
      .clk_i  (clk_i),
      .load_i (cmd_i.upd_start),
      .step_i (cmd_i.div_step),
      .num_i  (num),
      .den_i  (period_q[c]),
      .quo_o  (quo[c])
    );

    always_comb begin
      // zero period saturates; so does any quotient above the 20.8 range
      if (period_q[c] == '0 || quo[c] > NumW'(FreqMax)) q_sat = FreqMax;
      else                                              q_sat = quo[c][FreqW-1:0];
      sum       = {1'b0, freq_q[c]} + {1'b0, q_sat};
      freq_d[c] = zero_q[c] ? '0 : sum[FreqW:1];
      if (seen_q[c])                idle_d[c] = '0;
      else if (idle_q[c] < IdleMax) idle_d[c] = idle_q[c] + IdleW'(1);
      else                          idle_d[c] = idle_q[c];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        last_q[c]   <= '0;
        period_q[c] <= '0;
        seen_q[c]   <= 1'b0;
        idle_q[c]   <= '0;
        freq_q[c]   <= '0;
        zero_q[c]   <= 1'b0;
      end else begin
        if (edge_ok && (channel_i == 1'(c))) begin
          period_q[c] <= timestamp_i - last_q[c];
          last_q[c]   <= timestamp_i;
          seen_q[c]   <= 1'b1;
        end
        if (cmd_i.upd_start) begin
          idle_q[c] <= idle_d[c];
          seen_q[c] <= 1'b0;
          zero_q[c] <= (idle_d[c] > {1'b0, idle_limit_i});
        end
        if (cmd_i.commit) freq_q[c] <= freq_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_left_q  <= freq_q[0];
      out_right_q <= freq_q[1];
    end
  end

  assign freq_left_o  = out_left_q;
  assign freq_right_o = out_right_q;

endmodule

/* rtl/dual_encoder_speed_estimator.sv */
// Edge item: no result; the next item is taken the following cycle.
// Update item: result valid after the input transfer (35 steps of a
//   one-bit-per-cycle restoring divider per channel, then commit and handoff).
//   Input then stalls until the result is loaded, later if one is still pending.
// Reset (rst_ni low, async): all channel state zero, idle_limit 20,
//   tick_rate 1000000, no result pending.
module dual_encoder_speed_estimator import dese_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input item channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic              channel_i,
  input  logic [1:0]        level_i,
  input  logic [TsW-1:0]    timestamp_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FreqW-1:0]  freq_left_o,
  output logic [FreqW-1:0]  freq_right_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [LimitW-1:0] idle_limit_q;
  logic [RateW-1:0]  tick_rate_q;
  logic              wr_en;
  dp_cmd_t           cmd;

  // Register write completes on the access phase; pready is tied high,
  // so there are no wait states. Word select is paddr[2]; the byte offset
  // bits are ignored.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= LimitReset;
      tick_rate_q  <= RateReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegIdleLimit: idle_limit_q <= pwdata[LimitW-1:0];
        RegTickRate:  tick_rate_q  <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegIdleLimit: prdata = DataW'(idle_limit_q);
      RegTickRate:  prdata = DataW'(tick_rate_q);
      default:      prdata = '0;
    endcase
  end

  // Controller: accepts items only while idle, sequences the divide,
  // commits the averaged frequencies and hands them to the output register.
  dese_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Datapath: period capture on edges, idle counters and the cut-off
  // decision at the update transfer, two dividers running in parallel.
  dese_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .channel_i    (channel_i),
    .level_i      (level_i),
    .timestamp_i  (timestamp_i),
    .idle_limit_i (idle_limit_q),
    .tick_rate_i  (tick_rate_q),
    .freq_left_o  (freq_left_o),
    .freq_right_o (freq_right_o)
  );

endmodule
